[hdl/sha1_block_compression_macros.svh]
// Assertion macros shared by the SHA-1 compression checkers.
// No dependencies; included by the checker file.
`ifndef SHA1_BLOCK_COMPRESSION_MACROS_SVH
`define SHA1_BLOCK_COMPRESSION_MACROS_SVH

// next-cycle implication, off while reset is asserted
`define SHA1BC_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycle
`define SHA1BC_CHK_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sha1bc_pkg.sv]
// Shared types, constants and round functions for the SHA-1 compression block.
// No dependencies; used by all sha1bc modules.
`default_nettype none

package sha1bc_pkg;

    localparam int WORD_W       = 32;
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUNDS       = 80;
    localparam int QUEUE_DEPTH  = 4;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RND_W  = $clog2(ROUNDS);
    localparam int CNT_W  = $clog2(BLOCK_WORDS);
    localparam int DIDX_W = $clog2(DIGEST_WORDS);

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [DIGEST_WORDS-1:0] t_chain;

    localparam t_chain INIT_CHAIN = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam t_word K_0 = 32'h5a827999;
    localparam t_word K_1 = 32'h6ed9eba1;
    localparam t_word K_2 = 32'h8f1bbcdc;
    localparam t_word K_3 = 32'hca62c1d6;

    typedef struct packed {
        t_word word;
        logic  reload;
        logic  last;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic   load;
        t_chain chain;
    } t_digest_req;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    function automatic t_word rotl(input t_word x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_word round_k(input logic [RND_W-1:0] r);
        t_word k;
        if (r < RND_W'(20))      k = K_0;
        else if (r < RND_W'(40)) k = K_1;
        else if (r < RND_W'(60)) k = K_2;
        else                     k = K_3;
        return k;
    endfunction

    function automatic t_word round_f(input logic [RND_W-1:0] r,
                                      input t_word b, input t_word c, input t_word d);
        t_word f;
        if (r < RND_W'(20))      f = (b & c) ^ (~b & d);
        else if (r < RND_W'(40)) f = b ^ c ^ d;
        else if (r < RND_W'(60)) f = (b & c) ^ (b & d) ^ (c & d);
        else                     f = b ^ c ^ d;
        return f;
    endfunction

endpackage

`default_nettype wire

[hdl/sha1_block_compression.sv]
// SHA-1 block compression over 32-bit big-endian words of a padded message.
// A four-entry command queue sits between the word front end and the round
// engine. The engine loads a block at one word per cycle while commands are
// queued, then runs the SHA-1 rounds at one round per cycle, then the chaining
// add; words keep being taken until the queue fills. The round engine, not the
// front end, limits sustained throughput. The digest is read out as five
// words, one per pop.
// Depends on sha1bc_pkg, sha1bc_front, sha1bc_back, sha1bc_out.
`default_nettype none

module sha1_block_compression (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire sha1bc_pkg::t_word i_message_word,
    input  wire logic              i_start_message,
    input  wire logic              i_end_message,
    output logic                   empty,
    input  wire logic              pop,
    output sha1bc_pkg::t_word      o_digest_word,
    output logic                   o_digest_last
);
    import sha1bc_pkg::*;

    logic        cmd_valid;
    t_cmd        cmd;
    logic        take;
    t_digest_req req;
    logic        out_ready;

    sha1bc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_word      (i_message_word),
        .i_start     (i_start_message),
        .i_end       (i_end_message),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_take      (take)
    );

    sha1bc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_take      (take),
        .o_req       (req),
        .i_out_ready (out_ready)
    );

    sha1bc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ready (out_ready),
        .o_empty (empty),
        .i_pop   (pop),
        .o_word  (o_digest_word),
        .o_last  (o_digest_last)
    );

endmodule

`default_nettype wire

[hdl/sha1bc_front.sv]
// Front end: accepts message words, tracks block position, queues commands.
// Depends on sha1bc_pkg.
`default_nettype none

module sha1bc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire sha1bc_pkg::t_word i_word,
    input  wire logic              i_start,
    input  wire logic              i_end,
    output logic                   o_cmd_valid,
    output sha1bc_pkg::t_cmd       o_cmd,
    input  wire logic              i_take
);
    import sha1bc_pkg::*;

    t_cmd               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   pos;
    logic               accept;
    logic               deq;
    t_cmd               cmd_in;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_count != '0);
    assign deq         = i_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    // word position within the block after a possible restart
    assign pos           = i_start ? '0 : r_cnt;
    assign cmd_in.word   = i_word;
    assign cmd_in.reload = i_start;
    assign cmd_in.last   = (pos == CNT_W'(BLOCK_WORDS - 1));
    assign cmd_in.emit   = i_end && cmd_in.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_wr  <= r_wr + 1'b1;
                r_cnt <= pos + 1'b1;
            end
            if (deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (accept && !deq) begin
                r_count <= r_count + 1'b1;
            end else if (!accept && deq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[hdl/sha1bc_back.sv]
// Back end: schedule window, one SHA-1 round per cycle, chaining update.
// Depends on sha1bc_pkg.
`default_nettype none

module sha1bc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire sha1bc_pkg::t_cmd  i_cmd,
    output logic                   o_take,
    output sha1bc_pkg::t_digest_req o_req,
    input  wire logic              i_out_ready
);
    import sha1bc_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_chain             r_chain;
    t_chain             r_wk;
    t_word              r_sched [BLOCK_WORDS];
    logic [RND_W-1:0]   r_round;
    logic               r_emit;
    t_word              w_new;
    t_word              tmp;
    logic               take;
    logic               last_round;

    assign take       = (r_state == ST_LOAD) && i_cmd_valid;
    assign last_round = (r_round == RND_W'(ROUNDS - 1));

    // r_sched[j] holds w[t+j]; index 0 is the word used this round
    assign w_new = rotl(r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0], 1);
    assign tmp   = rotl(r_wk[0], 5) + round_f(r_round, r_wk[1], r_wk[2], r_wk[3])
                 + r_wk[4] + round_k(r_round) + r_sched[0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (take && i_cmd.last) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (last_round) n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = r_emit ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                if (i_out_ready) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_take      = take;
        o_req.load  = (r_state == ST_EMIT);
        o_req.chain = r_chain;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_chain <= INIT_CHAIN;
            r_round <= '0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                if (i_cmd.reload) r_chain <= INIT_CHAIN;
                if (i_cmd.last) begin
                    r_round <= '0;
                    r_emit  <= i_cmd.emit;
                end
            end
            if (r_state == ST_ROUND) begin
                r_round <= r_round + 1'b1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_wk[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                r_sched[j] <= r_sched[j+1];
            end
            r_sched[BLOCK_WORDS-1] <= i_cmd.word;
            if (i_cmd.last) begin
                r_wk <= i_cmd.reload ? INIT_CHAIN : r_chain;
            end
        end else if (r_state == ST_ROUND) begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                r_sched[j] <= r_sched[j+1];
            end
            r_sched[BLOCK_WORDS-1] <= w_new;
            r_wk[0] <= tmp;
            r_wk[1] <= r_wk[0];
            r_wk[2] <= rotl(r_wk[1], 30);
            r_wk[3] <= r_wk[2];
            r_wk[4] <= r_wk[3];
        end
    end

endmodule

`default_nettype wire

[hdl/sha1bc_out.sv]
// Digest buffer: holds a finished digest and hands it out one word at a time.
// Depends on sha1bc_pkg.
`default_nettype none

module sha1bc_out (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire sha1bc_pkg::t_digest_req i_req,
    output logic                         o_ready,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output sha1bc_pkg::t_word            o_word,
    output logic                         o_last
);
    import sha1bc_pkg::*;

    t_chain              r_dig;
    logic [DIDX_W-1:0]   r_idx;
    logic                r_busy;
    logic                deq;

    assign o_ready = !r_busy;
    assign o_empty = !r_busy;
    assign o_word  = r_dig[r_idx];
    assign o_last  = (r_idx == DIDX_W'(DIGEST_WORDS - 1));
    assign deq     = i_pop && r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (!r_busy) begin
            if (i_req.load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end
        end else if (deq) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.load) begin
            r_dig <= i_req.chain;
        end
    end

endmodule

`default_nettype wire

[hdl/sha1bc_checker.sv]
// Port-level checks for sha1_block_compression, bound to the top level.
// Depends on sha1bc_pkg and sha1_block_compression_macros.svh.
`default_nettype none
`include "sha1_block_compression_macros.svh"

module sha1bc_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire sha1bc_pkg::t_word o_digest_word,
    input wire logic              o_digest_last
);

    // digest words come in runs of five: no gap before the last one
    `SHA1BC_CHK_NEXT(a_run_continues, !empty && pop && !o_digest_last, !empty, "digest run broke before last word")

    `SHA1BC_CHK_NEXT(a_run_ends, !empty && pop && o_digest_last, empty, "word shown right after last digest word")

    `SHA1BC_CHK_NEXT(a_word_holds, !empty && !pop, !empty && $stable(o_digest_word) && $stable(o_digest_last), "waiting digest word changed")

    `SHA1BC_CHK_RST(a_reset_clear, !i_rst_n, empty && !full, "queues not clear after reset")

endmodule

bind sha1_block_compression sha1bc_checker u_sha1bc_checker (.*);

`default_nettype wire
